[sv/hlru_pkg.sv]
// Shared types and constants for the hashed LRU identifier remap table.
// No dependencies.
package hlru_pkg;

    localparam logic [31:0] PASS_FAIL     = 32'hffff_fffe;
    localparam int          REG_MAP_EN    = 0;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_HEAD_RD, ST_HEAD, ST_WALK,
        ST_T0, ST_T1, ST_T2, ST_T3, ST_T4,
        ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7,
        ST_DONE
    } state_t;

endpackage

[sv/hashed_lru_id_remap_table.sv]
// Top level of the hashed LRU identifier remap table: sequencer, tables, APB.
// Depends on hlru_pkg, hlru_ram and hlru_home.
//
//  channel | ports                              | moves
//  s_      | s_valid s_ready s_identifier        | one identifier word in
//  m_      | m_valid m_ready m_mapped_identifier | one mapped word out
//  apb     | psel penable pwrite paddr pwdata    | mapping_enabled at address 0
//
// Pass-through words go from idle straight to the output stage; a mapped word
// reads its chain head, walks the chain and relinks the lists, all through
// tables with one read and one write port each. After reset a clearing pass
// writes every table entry; s_ready stays low until it ends. One word is in
// work at a time; the next is taken while a result waits in the output register.
module hashed_lru_id_remap_table
    import hlru_pkg::*;
#(
    parameter int ENTRIES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_identifier,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_mapped_identifier,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = $clog2(ENTRIES);
    localparam int HW = IW + 1;
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);
    localparam logic [HW-1:0] HEAD_NONE = {1'b1, {IW{1'b0}}};

    state_t state_reg, state_next;

    logic          en_reg;
    logic [31:0]   id_reg, id_next;
    logic          pass_reg, pass_next;
    logic [IW-1:0] si_reg, si_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [IW-1:0] hf_reg, hf_next;
    logic [IW-1:0] found_reg, found_next;
    logic [IW-1:0] oldest_reg, oldest_next;
    logic [IW-1:0] n_reg, n_next;
    logic [IW-1:0] p_reg, p_next;
    logic [IW-1:0] po_reg, po_next;
    logic [IW-1:0] steps_reg, steps_next;
    logic [IW-1:0] clr_reg, clr_next;
    logic [31:0]   old_id_reg, old_id_next;
    logic          m_valid_reg, m_valid_next;
    logic [31:0]   m_data_reg, m_data_next;

    logic [IW-1:0] in_home, oh;

    // table ports
    logic          slot_we, head_we, cp_we, cn_we, rp_we, rn_we;
    logic [IW-1:0] slot_wa, head_wa, cp_wa, cn_wa, rp_wa, rn_wa;
    logic [IW-1:0] slot_ra, head_ra, cp_ra, cn_ra, rp_ra, rn_ra;
    logic [31:0]   slot_wd, slot_rd;
    logic [HW-1:0] head_wd, head_rd;
    logic [IW-1:0] cp_wd, cp_rd, cn_wd, cn_rd, rp_wd, rp_rd, rn_wd, rn_rd;

    hlru_home #(.ENTRIES(ENTRIES)) u_home_in  (.id(s_identifier), .home(in_home));
    hlru_home #(.ENTRIES(ENTRIES)) u_home_old (.id(old_id_reg),   .home(oh));

    hlru_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_slot (.aclk(aclk), .we(slot_we),
        .waddr(slot_wa), .wdata(slot_wd), .raddr(slot_ra), .rdata(slot_rd));
    hlru_ram #(.WIDTH(HW), .DEPTH(ENTRIES)) u_head (.aclk(aclk), .we(head_we),
        .waddr(head_wa), .wdata(head_wd), .raddr(head_ra), .rdata(head_rd));
    hlru_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_cprev (.aclk(aclk), .we(cp_we),
        .waddr(cp_wa), .wdata(cp_wd), .raddr(cp_ra), .rdata(cp_rd));
    hlru_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_cnext (.aclk(aclk), .we(cn_we),
        .waddr(cn_wa), .wdata(cn_wd), .raddr(cn_ra), .rdata(cn_rd));
    hlru_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_rprev (.aclk(aclk), .we(rp_we),
        .waddr(rp_wa), .wdata(rp_wd), .raddr(rp_ra), .rdata(rp_rd));
    hlru_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_rnext (.aclk(aclk), .we(rn_we),
        .waddr(rn_wa), .wdata(rn_wd), .raddr(rn_ra), .rdata(rn_rd));

    assign s_ready             = (state_reg == ST_IDLE);
    assign m_valid             = m_valid_reg;
    assign m_mapped_identifier = m_data_reg;
    assign pready              = 1'b1;
    assign prdata              = {31'd0, en_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg <= 1'b0;
        end else if (psel && penable && pwrite && (paddr == 1'(REG_MAP_EN))) begin
            en_reg <= pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            oldest_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            oldest_reg  <= oldest_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg     <= id_next;
        pass_reg   <= pass_next;
        si_reg     <= si_next;
        cur_reg    <= cur_next;
        hf_reg     <= hf_next;
        found_reg  <= found_next;
        n_reg      <= n_next;
        p_reg      <= p_next;
        po_reg     <= po_next;
        steps_reg  <= steps_next;
        old_id_reg <= old_id_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        id_next      = id_reg;
        pass_next    = pass_reg;
        si_next      = si_reg;
        cur_next     = cur_reg;
        hf_next      = hf_reg;
        found_next   = found_reg;
        oldest_next  = oldest_reg;
        n_next       = n_reg;
        p_next       = p_reg;
        po_next      = po_reg;
        steps_next   = steps_reg;
        clr_next     = clr_reg;
        old_id_next  = old_id_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;

        slot_we = 1'b0; slot_wa = found_reg; slot_wd = id_reg; slot_ra = si_reg;
        head_we = 1'b0; head_wa = si_reg; head_wd = HEAD_NONE; head_ra = si_reg;
        cp_we = 1'b0; cp_wa = found_reg; cp_wd = found_reg; cp_ra = found_reg;
        cn_we = 1'b0; cn_wa = found_reg; cn_wd = found_reg; cn_ra = found_reg;
        rp_we = 1'b0; rp_wa = found_reg; rp_wd = found_reg; rp_ra = oldest_reg;
        rn_we = 1'b0; rn_wa = found_reg; rn_wd = found_reg; rn_ra = found_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                slot_we = 1'b1; slot_wa = clr_reg; slot_wd = '0;
                head_we = 1'b1; head_wa = clr_reg; head_wd = HEAD_NONE;
                cp_we = 1'b1; cp_wa = clr_reg; cp_wd = clr_reg;
                cn_we = 1'b1; cn_wa = clr_reg; cn_wd = clr_reg;
                rp_we = 1'b1; rp_wa = clr_reg;
                rp_wd = (clr_reg == '0) ? LAST : clr_reg - IW'(1);
                rn_we = 1'b1; rn_wa = clr_reg;
                rn_wd = (clr_reg == LAST) ? '0 : clr_reg + IW'(1);
                clr_next = clr_reg + IW'(1);
                if (clr_reg == LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    si_next = in_home;
                    if (!en_reg) begin
                        pass_next  = 1'b1;
                        id_next    = (s_identifier[15:0] != 16'd0) ? s_identifier : PASS_FAIL;
                        state_next = ST_DONE;
                    end else if (s_identifier[31:1] == 31'd0) begin
                        pass_next  = 1'b1;
                        id_next    = s_identifier;
                        state_next = ST_DONE;
                    end else begin
                        pass_next  = 1'b0;
                        id_next    = s_identifier;
                        state_next = ST_HEAD_RD;
                    end
                end
            end
            ST_HEAD_RD: begin
                state_next = ST_HEAD;
            end
            ST_HEAD: begin
                if (head_rd[IW]) begin
                    if (slot_rd == 32'd0) begin
                        // empty home slot with no chain: claim it
                        slot_we = 1'b1; slot_wa = si_reg;
                        head_we = 1'b1; head_wa = si_reg; head_wd = {1'b0, si_reg};
                        cp_we = 1'b1; cp_wa = si_reg; cp_wd = si_reg;
                        cn_we = 1'b1; cn_wa = si_reg; cn_wd = si_reg;
                        found_next = si_reg;
                        state_next = ST_T0;
                    end else begin
                        state_next = ST_M0;
                    end
                end else begin
                    hf_next    = head_rd[IW-1:0];
                    cur_next   = head_rd[IW-1:0];
                    steps_next = '0;
                    slot_ra    = head_rd[IW-1:0];
                    cn_ra      = head_rd[IW-1:0];
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (slot_rd == id_reg) begin
                    found_next = cur_reg;
                    state_next = ST_T0;
                end else if (cn_rd == hf_reg || steps_reg == LAST) begin
                    state_next = ST_M0;
                end else begin
                    cur_next   = cn_rd;
                    steps_next = steps_reg + IW'(1);
                    slot_ra    = cn_rd;
                    cn_ra      = cn_rd;
                end
            end
            ST_T0: begin
                rn_ra = found_reg;
                rp_ra = oldest_reg;
                state_next = ST_T1;
            end
            ST_T1: begin
                if (found_reg == oldest_reg) begin
                    oldest_next = rn_rd;
                    state_next  = ST_DONE;
                end else if (found_reg == rp_rd) begin
                    state_next = ST_DONE;
                end else begin
                    n_next     = rn_rd;
                    po_next    = rp_rd;
                    rp_ra      = found_reg;
                    state_next = ST_T2;
                end
            end
            ST_T2: begin
                // unlink from the ring
                rp_we = 1'b1; rp_wa = n_reg; rp_wd = rp_rd;
                rn_we = 1'b1; rn_wa = rp_rd; rn_wd = n_reg;
                p_next = rp_rd;
                if (n_reg == oldest_reg) begin
                    po_next = rp_rd;
                end
                state_next = ST_T3;
            end
            ST_T3: begin
                rp_we = 1'b1; rp_wa = found_reg; rp_wd = po_reg;
                rn_we = 1'b1; rn_wa = found_reg; rn_wd = oldest_reg;
                state_next = ST_T4;
            end
            ST_T4: begin
                rp_we = 1'b1; rp_wa = oldest_reg; rp_wd = found_reg;
                rn_we = 1'b1; rn_wa = po_reg;     rn_wd = found_reg;
                state_next = ST_DONE;
            end
            ST_M0: begin
                found_next = oldest_reg;
                slot_ra = oldest_reg;
                cp_ra   = oldest_reg;
                cn_ra   = oldest_reg;
                rn_ra   = oldest_reg;
                state_next = ST_M1;
            end
            ST_M1: begin
                // evict the oldest slot and drop it from its old chain
                oldest_next = rn_rd;
                old_id_next = slot_rd;
                slot_we = 1'b1; slot_wa = found_reg;
                cp_we = 1'b1; cp_wa = cn_rd; cp_wd = cp_rd;
                cn_we = 1'b1; cn_wa = cp_rd; cn_wd = cn_rd;
                n_next = cn_rd;
                state_next = ST_M2;
            end
            ST_M2: begin
                head_ra = oh;
                state_next = ST_M3;
            end
            ST_M3: begin
                if (head_rd == {1'b0, found_reg}) begin
                    head_we = 1'b1; head_wa = oh;
                    head_wd = (n_reg == found_reg) ? HEAD_NONE : {1'b0, n_reg};
                end
                state_next = ST_M4;
            end
            ST_M4: begin
                head_ra = si_reg;
                state_next = ST_M5;
            end
            ST_M5: begin
                if (head_rd[IW]) begin
                    cp_we = 1'b1; cn_we = 1'b1;
                    head_we = 1'b1; head_wd = {1'b0, found_reg};
                    state_next = ST_DONE;
                end else begin
                    hf_next = head_rd[IW-1:0];
                    cp_ra   = head_rd[IW-1:0];
                    state_next = ST_M6;
                end
            end
            ST_M6: begin
                // splice in ahead of the chain head
                cp_we = 1'b1; cp_wa = hf_reg; cp_wd = found_reg;
                cn_we = 1'b1; cn_wa = cp_rd;  cn_wd = found_reg;
                p_next = cp_rd;
                state_next = ST_M7;
            end
            ST_M7: begin
                cp_we = 1'b1; cp_wd = p_reg;
                cn_we = 1'b1; cn_wd = hf_reg;
                head_we = 1'b1; head_wd = {1'b0, found_reg};
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pass_reg ? id_reg : (32'(found_reg) + 32'd2);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/hlru_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hlru_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/hlru_home.sv]
// Home slot hash: low half, else high half, else last slot, less two (0 and 1 go to the last two slots).
// No dependencies.
module hlru_home #(
    parameter int ENTRIES = 4096
) (
    input  logic [31:0]                  id,
    output logic [$clog2(ENTRIES)-1:0]   home
);

    localparam logic [16:0] ENT = 17'(ENTRIES);

    logic [16:0] h;
    logic [16:0] sel;

    always_comb begin
        h = {1'b0, id[15:0]};
        if (h >= ENT) begin
            h = {1'b0, id[31:16]};
            if (h >= ENT) begin
                h = ENT - 17'd1;
            end
        end
        sel  = (h >= 17'd2) ? (h - 17'd2) : (ENT - 17'd1 - h);
        home = sel[$clog2(ENTRIES)-1:0];
    end

endmodule

[sv/hlru_checker.sv]
// Port-level checks for the remap table, bound to the top level.
// Depends only on the top level's ports.
module hlru_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_mapped_identifier
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mapped_identifier))
        else $error("result word changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a word is in work");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("activity right after reset");

endmodule

bind hashed_lru_id_remap_table hlru_checker u_hlru_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_mapped_identifier(m_mapped_identifier)
);
